// ===== rtl/gjk_convex_polygon_overlap_top_assert.svh =====
// Assertion macros for the GJK overlap block.
// Used by rtl/gjk_convex_polygon_overlap_top.sv; no other dependencies.
`ifndef GJK_CONVEX_POLYGON_OVERLAP_TOP_ASSERT_SVH
`define GJK_CONVEX_POLYGON_OVERLAP_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define GJK_ASSERT_HOLDS(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define GJK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GJK_ASSERT_HOLDS(lbl, clk, rst_n, ante, cons, msg)
`define GJK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/gjk_pkg.sv =====
// Shared constants for the GJK convex polygon overlap block.
// No dependencies; used by rtl/gjk_convex_polygon_overlap_top.sv.
`default_nettype none
package gjk_pkg;
    localparam int MAX_VERTICES_DEF = 16;
    localparam int COORD_BITS_DEF   = 16;
    localparam int LIMIT_W          = 8;
    localparam logic [LIMIT_W-1:0] ITER_LIMIT_RESET = 8'd64;
endpackage
`default_nettype wire

// ===== rtl/gjk_convex_polygon_overlap_top.sv =====
// GJK overlap test of two convex polygons, with its vertex stores and sequencer.
// Depends on rtl/gjk_pkg.sv and rtl/gjk_convex_polygon_overlap_top_assert.svh.
//
// While idle, the block loads vertex words one per cycle into two on-chip stores, body 0
// and body 1. The word that carries the last vertex of body 1 starts the test; the block
// then takes no words until it is done. The test runs on one shared multiply-accumulate
// unit: first the initial direction, then per GJK iteration the support search and its
// check (each vertex needs a store read and two multiplies) and the simplex update. The
// first support search follows the initial direction without the iteration step. A
// pending result does not block loading of the next pair, only the word that would start
// the next test.
`default_nettype none
`include "gjk_convex_polygon_overlap_top_assert.svh"
module gjk_convex_polygon_overlap_top #(
    parameter int MAX_VERTICES = gjk_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = gjk_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          body,
    input  logic signed [COORD_BITS-1:0]  vertex_x,
    input  logic signed [COORD_BITS-1:0]  vertex_y,
    input  logic                          last_of_body,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          collide,
    output logic                          timed_out,
    output logic [gjk_pkg::LIMIT_W-1:0]   iterations,
    output logic                          load_error,
    input  logic                          cfg_write_en,
    input  logic [gjk_pkg::LIMIT_W-1:0]   cfg_write_data
);
    import gjk_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int IW  = $clog2(MAX_VERTICES);
    localparam int CW  = $clog2(MAX_VERTICES + 2);
    localparam int SW  = C + IW + 1;
    localparam int DW  = SW + CW + 2;
    localparam int MW  = C + 2;
    localparam int PW  = DW + MW + 1;
    localparam int PTW = C + 1;
    localparam int VW  = C + 2;

    typedef enum logic [4:0] {
        S_IDLE, S_I0, S_I1, S_I2, S_I3, S_IZ, S_TOP, S_SLD, S_SX, S_SY, S_SDN,
        S_CX, S_CY, S_LX, S_LY, S_TCX, S_TCY, S_TAX, S_TAY, S_TBX, S_TBY
    } state_t;

    state_t state_reg;

    logic [2*C-1:0] body0_mem [MAX_VERTICES];
    logic [2*C-1:0] body1_mem [MAX_VERTICES];
    logic [2*C-1:0] rd0_reg, rd1_reg;

    logic [CW-1:0] cnt0_reg, cnt1_reg, cnt0_new, cnt1_new;
    logic signed [SW-1:0] sum0x_reg, sum0y_reg, sum1x_reg, sum1y_reg;
    logic signed [DW-1:0] dx_reg, dy_reg;
    logic signed [PW-1:0] acc_reg, best_reg;
    logic [IW-1:0] i_reg;
    logic side_reg, first_reg;
    logic [1:0] size_reg;
    logic signed [C-1:0] sel0x_reg, sel0y_reg, sel1x_reg, sel1y_reg;
    logic signed [PTW-1:0] ax_reg, ay_reg, p0x_reg, p0y_reg, p1x_reg, p1y_reg;
    logic signed [PTW-1:0] aox_reg, aoy_reg;
    logic signed [VW-1:0] abx_reg, aby_reg, acx_reg, acy_reg;
    logic crpos_reg, crneg_reg;
    logic [LIMIT_W-1:0] ctr_reg, limit_reg, iter_reg;
    logic out_valid_reg, collide_reg, timed_reg, err_reg;

    logic in_accept, wr0, wr1, full0, full1, start, load_bad;
    logic signed [DW-1:0] mul_a;
    logic signed [MW-1:0] mul_b;
    logic signed [DW+MW-1:0] prod;
    logic signed [PW-1:0] mac_base, mac;
    logic mac_clr, mac_sub, mac_pos, mac_neg;
    logic signed [C-1:0] rdx, rdy;
    logic signed [CW:0] cnt0_s, cnt1_s;
    logic better, last_idx;
    logic done_now, done_col, done_to;

    assign in_ready  = (state_reg == S_IDLE) && !(out_valid_reg && body && last_of_body);
    assign in_accept = in_valid && in_ready;
    assign full0     = cnt0_reg >= CW'(MAX_VERTICES);
    assign full1     = cnt1_reg >= CW'(MAX_VERTICES);
    assign wr0       = in_accept && !body && !full0;
    assign wr1       = in_accept && body && !full1;
    assign cnt0_new  = full0 ? CW'(MAX_VERTICES + 1) : cnt0_reg + CW'(1);
    assign cnt1_new  = full1 ? CW'(MAX_VERTICES + 1) : cnt1_reg + CW'(1);
    assign start     = in_accept && body && last_of_body;
    assign load_bad  = (cnt0_reg == '0) || (cnt0_reg > CW'(MAX_VERTICES))
                    || (cnt1_new > CW'(MAX_VERTICES));

    assign out_valid  = out_valid_reg;
    assign collide    = collide_reg;
    assign timed_out  = timed_reg;
    assign iterations = iter_reg;
    assign load_error = err_reg;

    // Vertex stores: one write port at load, one registered read at the search index.
    always_ff @(posedge clk)
    begin
        if (wr0)
        begin
            body0_mem[cnt0_reg[IW-1:0]] <= {vertex_y, vertex_x};
        end
        if (wr1)
        begin
            body1_mem[cnt1_reg[IW-1:0]] <= {vertex_y, vertex_x};
        end
        rd0_reg <= body0_mem[i_reg];
        rd1_reg <= body1_mem[i_reg];
    end

    assign rdx    = side_reg ? signed'(rd1_reg[C-1:0]) : signed'(rd0_reg[C-1:0]);
    assign rdy    = side_reg ? signed'(rd1_reg[2*C-1:C]) : signed'(rd0_reg[2*C-1:C]);
    assign cnt0_s = signed'({1'b0, cnt0_reg});
    assign cnt1_s = signed'({1'b0, cnt1_reg});

    // Operand selection for the shared multiply-accumulate unit.
    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        mac_clr = 1'b1;
        mac_sub = 1'b0;
        case (state_reg)
            S_I0:  begin mul_a = DW'(sum0x_reg); mul_b = MW'(cnt1_s); end
            S_I1:  begin mul_a = DW'(sum1x_reg); mul_b = MW'(cnt0_s);
                         mac_clr = 1'b0; mac_sub = 1'b1; end
            S_I2:  begin mul_a = DW'(sum0y_reg); mul_b = MW'(cnt1_s); end
            S_I3:  begin mul_a = DW'(sum1y_reg); mul_b = MW'(cnt0_s);
                         mac_clr = 1'b0; mac_sub = 1'b1; end
            S_SX:  begin mul_a = dx_reg; mul_b = MW'(rdx); end
            S_SY:  begin mul_a = dy_reg; mul_b = MW'(rdy); mac_clr = 1'b0; end
            S_CX:  begin mul_a = dx_reg; mul_b = MW'(ax_reg); end
            S_CY:  begin mul_a = dy_reg; mul_b = MW'(ay_reg); mac_clr = 1'b0; end
            S_LX:  begin mul_a = DW'(abx_reg); mul_b = MW'(aoy_reg); end
            S_LY:  begin mul_a = DW'(aby_reg); mul_b = MW'(aox_reg);
                         mac_clr = 1'b0; mac_sub = 1'b1; end
            S_TCX: begin mul_a = DW'(abx_reg); mul_b = MW'(acy_reg); end
            S_TCY: begin mul_a = DW'(aby_reg); mul_b = MW'(acx_reg);
                         mac_clr = 1'b0; mac_sub = 1'b1; end
            S_TAX: begin mul_a = DW'(acy_reg); mul_b = MW'(aox_reg); mac_sub = 1'b1; end
            S_TAY: begin mul_a = DW'(acx_reg); mul_b = MW'(aoy_reg); mac_clr = 1'b0; end
            S_TBX: begin mul_a = DW'(aby_reg); mul_b = MW'(aox_reg); mac_sub = 1'b1; end
            S_TBY: begin mul_a = DW'(abx_reg); mul_b = MW'(aoy_reg); mac_clr = 1'b0; end
            default: begin mul_a = '0; end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign mac_base = mac_clr ? '0 : acc_reg;
    assign mac      = mac_sub ? mac_base - PW'(prod) : mac_base + PW'(prod);
    assign mac_neg  = mac[PW-1];
    assign mac_pos  = !mac[PW-1] && (mac != '0);

    // Body 1 is searched against the negated direction, so there the smallest dot wins.
    assign better   = (i_reg == '0) || (side_reg ? (mac < best_reg) : (mac > best_reg));
    assign last_idx = ({{(CW-IW){1'b0}}, i_reg} + CW'(1)) == (side_reg ? cnt1_reg : cnt0_reg);

    always_comb
    begin
        done_now = 1'b0;
        done_col = 1'b0;
        done_to  = 1'b0;
        case (state_reg)
            S_TOP:
            begin
                done_to  = ctr_reg >= limit_reg;
                done_now = done_to;
            end
            S_CY:
            begin
                done_now = !mac_pos;
            end
            S_TBY:
            begin
                done_col = (crpos_reg && mac_pos) || (crneg_reg && mac_neg);
                done_now = done_col;
            end
            default:
            begin
                done_now = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt0_reg      <= '0;
            cnt1_reg      <= '0;
            sum0x_reg     <= '0;
            sum0y_reg     <= '0;
            sum1x_reg     <= '0;
            sum1y_reg     <= '0;
            size_reg      <= '0;
            ctr_reg       <= '0;
            limit_reg     <= ITER_LIMIT_RESET;
            out_valid_reg <= 1'b0;
            first_reg     <= 1'b0;
            side_reg      <= 1'b0;
            i_reg         <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                limit_reg <= cfg_write_data;
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (done_now)
            begin
                out_valid_reg <= 1'b1;
                collide_reg   <= done_col;
                timed_reg     <= done_to;
                iter_reg      <= ctr_reg;
                err_reg       <= 1'b0;
                state_reg     <= S_IDLE;
                cnt0_reg      <= '0;
                cnt1_reg      <= '0;
                sum0x_reg     <= '0;
                sum0y_reg     <= '0;
                sum1x_reg     <= '0;
                sum1y_reg     <= '0;
                size_reg      <= '0;
                ctr_reg       <= '0;
            end
            else
            begin
                case (state_reg)
                    S_IDLE:
                    begin
                        if (in_accept && !body)
                        begin
                            cnt0_reg <= cnt0_new;
                            if (!full0)
                            begin
                                sum0x_reg <= sum0x_reg + SW'(vertex_x);
                                sum0y_reg <= sum0y_reg + SW'(vertex_y);
                            end
                        end
                        if (in_accept && body)
                        begin
                            cnt1_reg <= cnt1_new;
                            if (!full1)
                            begin
                                sum1x_reg <= sum1x_reg + SW'(vertex_x);
                                sum1y_reg <= sum1y_reg + SW'(vertex_y);
                            end
                        end
                        if (start)
                        begin
                            ctr_reg <= '0;
                            if (load_bad)
                            begin
                                out_valid_reg <= 1'b1;
                                collide_reg   <= 1'b0;
                                timed_reg     <= 1'b0;
                                iter_reg      <= '0;
                                err_reg       <= 1'b1;
                                cnt0_reg      <= '0;
                                cnt1_reg      <= '0;
                                sum0x_reg     <= '0;
                                sum0y_reg     <= '0;
                                sum1x_reg     <= '0;
                                sum1y_reg     <= '0;
                                size_reg      <= '0;
                            end
                            else
                            begin
                                state_reg <= S_I0;
                            end
                        end
                    end
                    S_I0:
                    begin
                        acc_reg   <= mac;
                        state_reg <= S_I1;
                    end
                    S_I1:
                    begin
                        dx_reg    <= mac[DW-1:0];
                        state_reg <= S_I2;
                    end
                    S_I2:
                    begin
                        acc_reg   <= mac;
                        state_reg <= S_I3;
                    end
                    S_I3:
                    begin
                        dy_reg    <= mac[DW-1:0];
                        state_reg <= S_IZ;
                    end
                    S_IZ:
                    begin
                        // A zero centroid difference falls back to the x axis.
                        if (dx_reg == '0 && dy_reg == '0)
                        begin
                            dx_reg <= DW'(1);
                        end
                        first_reg <= 1'b1;
                        side_reg  <= 1'b0;
                        i_reg     <= '0;
                        state_reg <= S_SLD;
                    end
                    S_TOP:
                    begin
                        ctr_reg   <= ctr_reg + LIMIT_W'(1);
                        side_reg  <= 1'b0;
                        i_reg     <= '0;
                        state_reg <= S_SLD;
                    end
                    S_SLD:
                    begin
                        state_reg <= S_SX;
                    end
                    S_SX:
                    begin
                        acc_reg   <= mac;
                        state_reg <= S_SY;
                    end
                    S_SY:
                    begin
                        if (better)
                        begin
                            best_reg <= mac;
                            if (side_reg)
                            begin
                                sel1x_reg <= rdx;
                                sel1y_reg <= rdy;
                            end
                            else
                            begin
                                sel0x_reg <= rdx;
                                sel0y_reg <= rdy;
                            end
                        end
                        if (last_idx)
                        begin
                            i_reg <= '0;
                            if (side_reg)
                            begin
                                state_reg <= S_SDN;
                            end
                            else
                            begin
                                side_reg  <= 1'b1;
                                state_reg <= S_SLD;
                            end
                        end
                        else
                        begin
                            i_reg     <= i_reg + IW'(1);
                            state_reg <= S_SLD;
                        end
                    end
                    S_SDN:
                    begin
                        ax_reg    <= PTW'(sel0x_reg) - PTW'(sel1x_reg);
                        ay_reg    <= PTW'(sel0y_reg) - PTW'(sel1y_reg);
                        state_reg <= S_CX;
                    end
                    S_CX:
                    begin
                        acc_reg   <= mac;
                        state_reg <= S_CY;
                    end
                    S_CY:
                    begin
                        aox_reg <= -ax_reg;
                        aoy_reg <= -ay_reg;
                        if (first_reg)
                        begin
                            p0x_reg   <= ax_reg;
                            p0y_reg   <= ay_reg;
                            size_reg  <= 2'd1;
                            dx_reg    <= -DW'(ax_reg);
                            dy_reg    <= -DW'(ay_reg);
                            first_reg <= 1'b0;
                            state_reg <= S_TOP;
                        end
                        else if (size_reg == 2'd1)
                        begin
                            p1x_reg   <= ax_reg;
                            p1y_reg   <= ay_reg;
                            size_reg  <= 2'd2;
                            abx_reg   <= VW'(p0x_reg) - VW'(ax_reg);
                            aby_reg   <= VW'(p0y_reg) - VW'(ay_reg);
                            state_reg <= S_LX;
                        end
                        else
                        begin
                            abx_reg   <= VW'(p1x_reg) - VW'(ax_reg);
                            aby_reg   <= VW'(p1y_reg) - VW'(ay_reg);
                            acx_reg   <= VW'(p0x_reg) - VW'(ax_reg);
                            acy_reg   <= VW'(p0y_reg) - VW'(ay_reg);
                            state_reg <= S_TCX;
                        end
                    end
                    S_LX:
                    begin
                        acc_reg   <= mac;
                        state_reg <= S_LY;
                    end
                    S_LY:
                    begin
                        // A collinear segment takes the fixed perpendicular.
                        if (mac_pos)
                        begin
                            dx_reg <= -DW'(aby_reg);
                            dy_reg <= DW'(abx_reg);
                        end
                        else
                        begin
                            dx_reg <= DW'(aby_reg);
                            dy_reg <= -DW'(abx_reg);
                        end
                        state_reg <= S_TOP;
                    end
                    S_TCX:
                    begin
                        acc_reg   <= mac;
                        state_reg <= S_TCY;
                    end
                    S_TCY:
                    begin
                        crpos_reg <= mac_pos;
                        crneg_reg <= mac_neg;
                        state_reg <= S_TAX;
                    end
                    S_TAX:
                    begin
                        acc_reg   <= mac;
                        state_reg <= S_TAY;
                    end
                    S_TAY:
                    begin
                        if ((crpos_reg && mac_neg) || (crneg_reg && mac_pos))
                        begin
                            state_reg <= S_TBX;
                        end
                        else
                        begin
                            if (crpos_reg)
                            begin
                                dx_reg <= -DW'(acy_reg);
                                dy_reg <= DW'(acx_reg);
                            end
                            else if (crneg_reg)
                            begin
                                dx_reg <= DW'(acy_reg);
                                dy_reg <= -DW'(acx_reg);
                            end
                            else
                            begin
                                dx_reg <= '0;
                                dy_reg <= '0;
                            end
                            p1x_reg   <= ax_reg;
                            p1y_reg   <= ay_reg;
                            size_reg  <= 2'd2;
                            state_reg <= S_TOP;
                        end
                    end
                    S_TBX:
                    begin
                        acc_reg   <= mac;
                        state_reg <= S_TBY;
                    end
                    S_TBY:
                    begin
                        p0x_reg <= p1x_reg;
                        p0y_reg <= p1y_reg;
                        p1x_reg <= ax_reg;
                        p1y_reg <= ay_reg;
                        if (crpos_reg)
                        begin
                            dx_reg <= DW'(aby_reg);
                            dy_reg <= -DW'(abx_reg);
                        end
                        else
                        begin
                            dx_reg <= -DW'(aby_reg);
                            dy_reg <= DW'(abx_reg);
                        end
                        size_reg  <= 2'd2;
                        state_reg <= S_TOP;
                    end
                    default:
                    begin
                        state_reg <= S_IDLE;
                    end
                endcase
            end
        end
    end

    `GJK_ASSERT_HOLDS(a_excl, clk, rst_n, out_valid_reg, !(collide_reg && timed_reg), "collide and timeout both set")
    `GJK_ASSERT_HOLDS(a_err_clean, clk, rst_n, out_valid_reg && err_reg, !collide_reg && !timed_reg && iter_reg == '0, "load error word carries other fields")
    `GJK_ASSERT_HOLDS(a_to_count, clk, rst_n, out_valid_reg && timed_reg, iter_reg == limit_reg, "timeout count differs from limit")
    `GJK_ASSERT_HOLDS(a_ctr_bound, clk, rst_n, state_reg != S_IDLE, ctr_reg <= limit_reg, "iteration counter passed the limit")
    `GJK_ASSERT_NEXT(a_start, clk, rst_n, start, out_valid_reg || state_reg == S_I0, "final vertex neither started nor reported")

endmodule
`default_nettype wire
